[hdl/session_heartbeat_supervisor_core_defines.svh]
// assertion macros for the session heartbeat supervisor
// expects clk and rst_n in the scope of each use; empty bodies when SYNTH is defined
`ifndef SESSION_HEARTBEAT_SUPERVISOR_CORE_DEFINES_SVH
`define SESSION_HEARTBEAT_SUPERVISOR_CORE_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SHS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shs assertion failed");
// next-cycle implication
`define SHS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shs assertion failed");
`else
`define SHS_ASSERT_IMP(lbl, ante, cons)
`define SHS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/shs_pkg.sv]
// shared types and constants for the session heartbeat supervisor
// no dependencies
package shs_pkg;

    // session codes
    typedef enum logic [1:0] {
        SES_DISC  = 2'd0,
        SES_STALE = 2'd1,
        SES_VALID = 2'd2
    } session_t;

    // request codes
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_CONNECT    = 3'd1;
    localparam logic [2:0] REQ_DISCONNECT = 3'd2;
    localparam logic [2:0] REQ_TEXT       = 3'd3;
    localparam logic [2:0] REQ_BINARY     = 3'd4;
    localparam logic [2:0] REQ_ERROR      = 3'd5;

    // text message kinds
    localparam logic [1:0] MSG_CORRUPT = 2'd0;
    localparam logic [1:0] MSG_PONG    = 2'd1;
    localparam logic [1:0] MSG_PING    = 2'd2;
    localparam logic [1:0] MSG_COMMAND = 2'd3;

    // led event codes
    localparam logic [1:0] LED_NONE = 2'd0;
    localparam logic [1:0] LED_CONN = 2'd1;
    localparam logic [1:0] LED_DISC = 2'd2;
    localparam logic [1:0] LED_ERR  = 2'd3;

    // configuration register indexes
    localparam int          CFG_IDX_W           = 3;
    localparam logic [2:0]  CFG_HB_PERIOD       = 3'd0;
    localparam logic [2:0]  CFG_PONG_TIMEOUT    = 3'd1;
    localparam logic [2:0]  CFG_CMD_IDLE_MAX    = 3'd2;
    localparam logic [2:0]  CFG_MIN_PROCESS_GAP = 3'd3;
    localparam logic [2:0]  CFG_SEND_GAP        = 3'd4;

    // configuration reset values
    localparam logic [31:0] HB_PERIOD_RST       = 32'd5000;
    localparam logic [31:0] PONG_TIMEOUT_RST    = 32'd15000;
    localparam logic [31:0] CMD_IDLE_MAX_RST    = 32'd1000;
    localparam logic [31:0] MIN_PROCESS_GAP_RST = 32'd50;
    localparam logic [31:0] SEND_GAP_RST        = 32'd50;

    // input item
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [1:0]  msg_kind;
        logic        has_seq;
        logic [31:0] seq_num;
        logic        has_data;
    } shs_req_t;

    // result item
    typedef struct packed {
        logic [1:0] session_state;
        logic       send_ping;
        logic       send_pong;
        logic       send_greeting;
        logic       drop_client;
        logic       send_stop;
        logic       forward_cmd;
        logic [1:0] led_event;
    } shs_rsp_t;

    // configuration register set
    typedef struct packed {
        logic [31:0] hb_period;
        logic [31:0] pong_timeout;
        logic [31:0] cmd_idle_max;
        logic [31:0] min_process_gap;
        logic [31:0] send_gap;
    } shs_cfg_t;

    // session tracking state
    typedef struct packed {
        session_t    session;
        logic        link_up;
        logic [31:0] last_ping_time;
        logic [31:0] last_reply_time;
        logic [31:0] last_valid_time;
        logic [31:0] last_process_stamp;
        logic [31:0] last_forward_time;
        logic [31:0] highest_seq;
    } shs_state_t;

endpackage

[hdl/shs_cfg_regs.sv]
// configuration registers of the session heartbeat supervisor
// depends on shs_pkg
module shs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [shs_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]                   wr_data,
    output shs_pkg::shs_cfg_t             cfg
);

    shs_pkg::shs_cfg_t cfg_reg;
    shs_pkg::shs_cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                shs_pkg::CFG_HB_PERIOD:       cfg_next.hb_period       = wr_data;
                shs_pkg::CFG_PONG_TIMEOUT:    cfg_next.pong_timeout    = wr_data;
                shs_pkg::CFG_CMD_IDLE_MAX:    cfg_next.cmd_idle_max    = wr_data;
                shs_pkg::CFG_MIN_PROCESS_GAP: cfg_next.min_process_gap = wr_data;
                shs_pkg::CFG_SEND_GAP:        cfg_next.send_gap        = wr_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hb_period       <= shs_pkg::HB_PERIOD_RST;
            cfg_reg.pong_timeout    <= shs_pkg::PONG_TIMEOUT_RST;
            cfg_reg.cmd_idle_max    <= shs_pkg::CMD_IDLE_MAX_RST;
            cfg_reg.min_process_gap <= shs_pkg::MIN_PROCESS_GAP_RST;
            cfg_reg.send_gap        <= shs_pkg::SEND_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/shs_event_logic.sv]
// per-item event decode and session state update, purely combinational
// depends on shs_pkg
module shs_event_logic (
    input  shs_pkg::shs_state_t st,
    input  shs_pkg::shs_cfg_t   cfg,
    input  shs_pkg::shs_req_t   item,
    output shs_pkg::shs_state_t st_next,
    output shs_pkg::shs_rsp_t   rsp
);

    logic [31:0] el_ping;
    logic [31:0] el_reply;
    logic [31:0] el_valid;
    logic [31:0] el_proc;
    logic [31:0] el_fwd;
    logic        seq_ok;

    // wrapping elapsed times
    assign el_ping  = item.now_ms - st.last_ping_time;
    assign el_reply = item.now_ms - st.last_reply_time;
    assign el_valid = item.now_ms - st.last_valid_time;
    assign el_proc  = item.now_ms - st.last_process_stamp;
    assign el_fwd   = item.now_ms - st.last_forward_time;
    assign seq_ok   = !item.has_seq || (item.seq_num > st.highest_seq);

    // event handling
    always_comb
    begin
        st_next = st;
        rsp     = '0;
        rsp.led_event = shs_pkg::LED_NONE;
        unique case (item.req_type)
            shs_pkg::REQ_TICK:
            begin
                if (st.link_up)
                begin
                    if (el_ping > cfg.hb_period)
                    begin
                        rsp.send_ping          = 1'b1;
                        st_next.last_ping_time = item.now_ms;
                    end
                    if (el_reply > cfg.pong_timeout)
                    begin
                        rsp.drop_client = 1'b1;
                        rsp.send_stop   = 1'b1;
                        st_next.link_up = 1'b0;
                        st_next.session = shs_pkg::SES_DISC;
                    end
                end
                // command silence drops a valid stream to stale
                if (st_next.session == shs_pkg::SES_VALID && el_valid > cfg.cmd_idle_max)
                begin
                    st_next.session = shs_pkg::SES_STALE;
                    rsp.send_stop   = 1'b1;
                end
            end
            shs_pkg::REQ_CONNECT:
            begin
                rsp.led_event           = shs_pkg::LED_CONN;
                rsp.send_greeting       = 1'b1;
                st_next.link_up         = 1'b1;
                st_next.session         = shs_pkg::SES_STALE;
                st_next.last_ping_time  = item.now_ms;
                st_next.last_reply_time = item.now_ms;
                st_next.last_valid_time = item.now_ms;
            end
            shs_pkg::REQ_DISCONNECT:
            begin
                rsp.led_event   = shs_pkg::LED_DISC;
                rsp.send_stop   = 1'b1;
                st_next.link_up = 1'b0;
                st_next.session = shs_pkg::SES_DISC;
            end
            shs_pkg::REQ_TEXT:
            begin
                if (item.msg_kind != shs_pkg::MSG_CORRUPT)
                begin
                    st_next.last_reply_time = item.now_ms;
                end
                if (item.msg_kind == shs_pkg::MSG_PING)
                begin
                    rsp.send_pong = 1'b1;
                end
                // command: sequence, anti-flood, data and send-interval checks
                if (item.msg_kind == shs_pkg::MSG_COMMAND && seq_ok)
                begin
                    if (item.has_seq)
                    begin
                        st_next.highest_seq = item.seq_num;
                    end
                    if (!(el_proc < cfg.min_process_gap))
                    begin
                        st_next.last_process_stamp = item.now_ms;
                        if (item.has_data)
                        begin
                            st_next.last_valid_time = item.now_ms;
                            st_next.session         = shs_pkg::SES_VALID;
                            if (el_fwd > cfg.send_gap)
                            begin
                                rsp.forward_cmd           = 1'b1;
                                st_next.last_forward_time = item.now_ms;
                            end
                        end
                    end
                end
            end
            shs_pkg::REQ_BINARY:
            begin
                st_next.last_reply_time = item.now_ms;
            end
            shs_pkg::REQ_ERROR:
            begin
                rsp.led_event = shs_pkg::LED_ERR;
            end
            default:
            begin
                st_next = st;
            end
        endcase
        rsp.session_state = st_next.session;
    end

endmodule

[hdl/session_heartbeat_supervisor_core.sv]
// an accepted item is registered, and its result register loads when the item advances
// one item per cycle unless rsp_ready stalls; the session update is a compare and select
// ready depends combinationally on rsp_ready through the result register's free slot
// reset: session disconnected, link down, all timestamps and highest sequence zero,
// configuration at its defaults; no clearing pass, items are taken right after reset
// depends on shs_pkg, shs_cfg_regs, shs_event_logic and the assertion macro header
`include "session_heartbeat_supervisor_core_defines.svh"
module session_heartbeat_supervisor_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  shs_pkg::shs_req_t             req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output shs_pkg::shs_rsp_t             rsp_item,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    shs_pkg::shs_cfg_t   cfg;
    shs_pkg::shs_state_t state_reg;
    shs_pkg::shs_state_t state_next;
    shs_pkg::shs_req_t   pipe_item_reg;
    logic                pipe_vld_reg;
    logic                pipe_vld_next;
    shs_pkg::shs_rsp_t   rsp_item_reg;
    shs_pkg::shs_rsp_t   rsp_item_next;
    logic                rsp_vld_reg;
    logic                rsp_vld_next;
    logic                advance;
    logic                req_fire;

    // configuration registers, always writable
    assign cfg_ready = 1'b1;

    shs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // event decode on the registered item
    shs_event_logic u_logic (
        .st      (state_reg),
        .cfg     (cfg),
        .item    (pipe_item_reg),
        .st_next (state_next),
        .rsp     (rsp_item_next)
    );

    // pipeline flow control
    assign advance   = pipe_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !pipe_vld_reg || advance;
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        pipe_vld_next = pipe_vld_reg;
        if (req_fire)
        begin
            pipe_vld_next = 1'b1;
        end
        else if (advance)
        begin
            pipe_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (advance)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    // control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= 1'b0;
            rsp_vld_reg  <= 1'b0;
            state_reg    <= '{session: shs_pkg::SES_DISC, default: '0};
        end
        else
        begin
            pipe_vld_reg <= pipe_vld_next;
            rsp_vld_reg  <= rsp_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            pipe_item_reg <= req_item;
        end
        if (advance)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_item  = rsp_item_reg;

    // checks
    `SHS_ASSERT_NXT(a_fire_fills_pipe, req_fire, pipe_vld_reg)
    `SHS_ASSERT_IMP(a_drop_disc, rsp_vld_reg && rsp_item_reg.drop_client, rsp_item_reg.session_state == shs_pkg::SES_DISC && rsp_item_reg.send_stop)
    `SHS_ASSERT_IMP(a_fwd_valid, rsp_vld_reg && rsp_item_reg.forward_cmd, rsp_item_reg.session_state == shs_pkg::SES_VALID)
    `SHS_ASSERT_IMP(a_greet_conn, rsp_vld_reg && rsp_item_reg.send_greeting, rsp_item_reg.led_event == shs_pkg::LED_CONN && state_reg.link_up)

endmodule

[test/tb.sv]
// self-checking testbench for session_heartbeat_supervisor_core
// directed event table then random timed event streams over several register settings
// depends on shs_pkg and the core rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         RESET_CYCLES    = 10;
    localparam int         N_PHASES        = 5;
    localparam int         ITEMS_PER_PHASE = 180;
    localparam int         STALL_MAX       = 15;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         QUIET_SPAN      = 40;
    localparam int         CFG_IDX_BITS    = shs_pkg::CFG_IDX_W;
    localparam logic [2:0] REQ_RSVD_LO     = 3'd6;
    localparam logic [2:0] REQ_RSVD_HI     = 3'd7;

    // one row of the directed event table
    typedef struct {
        shs_pkg::shs_req_t req;
        logic              typed;
        shs_pkg::shs_rsp_t rsp;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    shs_pkg::shs_req_t       req_item  = '0;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    shs_pkg::shs_rsp_t       rsp_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [31:0]             cfg_data  = '0;

    // predictor copy of registers and session tracking
    shs_pkg::shs_cfg_t   regs;
    shs_pkg::shs_state_t trk;
    shs_pkg::shs_rsp_t   rsp_due_q[$];
    shs_pkg::shs_rsp_t   rsp_due;
    dir_row_t            dir_tab[$];
    int                  n_fail       = 0;
    int                  quiet_cycles = 0;
    bit                  req_quiet    = 1'b0;
    bit                  rsp_quiet    = 1'b0;

    session_heartbeat_supervisor_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // wrapping millisecond difference
    function automatic logic [31:0] since(logic [31:0] now, logic [31:0] stamp);
        return now - stamp;
    endfunction

    function automatic shs_pkg::shs_req_t ev(logic [2:0] req_type, logic [31:0] now_ms,
                                             logic [1:0] msg_kind, logic has_seq,
                                             logic [31:0] seq_num, logic has_data);
        shs_pkg::shs_req_t r;
        r.req_type = req_type;
        r.now_ms   = now_ms;
        r.msg_kind = msg_kind;
        r.has_seq  = has_seq;
        r.seq_num  = seq_num;
        r.has_data = has_data;
        return r;
    endfunction

    function automatic shs_pkg::shs_rsp_t res(shs_pkg::session_t s, logic ping, logic pong,
                                              logic greet, logic drop, logic stop,
                                              logic fwd, logic [1:0] led);
        shs_pkg::shs_rsp_t o;
        o.session_state = s;
        o.send_ping     = ping;
        o.send_pong     = pong;
        o.send_greeting = greet;
        o.drop_client   = drop;
        o.send_stop     = stop;
        o.forward_cmd   = fwd;
        o.led_event     = led;
        return o;
    endfunction

    task automatic add_row(shs_pkg::shs_req_t req, logic typed, shs_pkg::shs_rsp_t rsp);
        dir_row_t row;
        row.req   = req;
        row.typed = typed;
        row.rsp   = rsp;
        dir_tab.push_back(row);
    endtask

    // session update for one event, returns the actions it causes
    function automatic shs_pkg::shs_rsp_t predict_event(shs_pkg::shs_req_t r);
        shs_pkg::shs_rsp_t o;
        o = '0;
        case (r.req_type)
            shs_pkg::REQ_TICK:
            begin
                if (trk.link_up)
                begin
                    if (since(r.now_ms, trk.last_ping_time) > regs.hb_period)
                    begin
                        o.send_ping        = 1'b1;
                        trk.last_ping_time = r.now_ms;
                    end
                    if (since(r.now_ms, trk.last_reply_time) > regs.pong_timeout)
                    begin
                        o.drop_client = 1'b1;
                        o.send_stop   = 1'b1;
                        trk.link_up   = 1'b0;
                        trk.session   = shs_pkg::SES_DISC;
                    end
                end
                // command stream went quiet
                if (trk.session == shs_pkg::SES_VALID &&
                    since(r.now_ms, trk.last_valid_time) > regs.cmd_idle_max)
                begin
                    trk.session = shs_pkg::SES_STALE;
                    o.send_stop = 1'b1;
                end
            end
            shs_pkg::REQ_CONNECT:
            begin
                o.led_event         = shs_pkg::LED_CONN;
                o.send_greeting     = 1'b1;
                trk.link_up         = 1'b1;
                trk.session         = shs_pkg::SES_STALE;
                trk.last_ping_time  = r.now_ms;
                trk.last_reply_time = r.now_ms;
                trk.last_valid_time = r.now_ms;
            end
            shs_pkg::REQ_DISCONNECT:
            begin
                o.led_event = shs_pkg::LED_DISC;
                o.send_stop = 1'b1;
                trk.link_up = 1'b0;
                trk.session = shs_pkg::SES_DISC;
            end
            shs_pkg::REQ_TEXT:
            begin
                if (r.msg_kind != shs_pkg::MSG_CORRUPT)
                begin
                    trk.last_reply_time = r.now_ms;
                    if (r.msg_kind == shs_pkg::MSG_PING)
                        o.send_pong = 1'b1;
                    else if (r.msg_kind == shs_pkg::MSG_COMMAND &&
                             !(r.has_seq && r.seq_num <= trk.highest_seq))
                    begin
                        // sequence, anti-flood, data and send interval checks
                        if (r.has_seq)
                            trk.highest_seq = r.seq_num;
                        if (since(r.now_ms, trk.last_process_stamp) >= regs.min_process_gap)
                        begin
                            trk.last_process_stamp = r.now_ms;
                            if (r.has_data)
                            begin
                                trk.last_valid_time = r.now_ms;
                                trk.session         = shs_pkg::SES_VALID;
                                if (since(r.now_ms, trk.last_forward_time) > regs.send_gap)
                                begin
                                    o.forward_cmd         = 1'b1;
                                    trk.last_forward_time = r.now_ms;
                                end
                            end
                        end
                    end
                end
            end
            shs_pkg::REQ_BINARY:
                trk.last_reply_time = r.now_ms;
            shs_pkg::REQ_ERROR:
                o.led_event = shs_pkg::LED_ERR;
            default:
                ;
        endcase
        o.session_state = trk.session;
        return o;
    endfunction

    // present one event item, record its expected result on acceptance
    task automatic send_event(shs_pkg::shs_req_t r, logic typed,
                              shs_pkg::shs_rsp_t typed_rsp);
        int                gap;
        shs_pkg::shs_rsp_t pred;
        gap = req_quiet ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pred = predict_event(r);
        rsp_due_q.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            shs_pkg::CFG_HB_PERIOD:       regs.hb_period       = val;
            shs_pkg::CFG_PONG_TIMEOUT:    regs.pong_timeout    = val;
            shs_pkg::CFG_CMD_IDLE_MAX:    regs.cmd_idle_max    = val;
            shs_pkg::CFG_MIN_PROCESS_GAP: regs.min_process_gap = val;
            shs_pkg::CFG_SEND_GAP:        regs.send_gap        = val;
            default:                      ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_regs(logic [31:0] ping, logic [31:0] pong, logic [31:0] cmd,
                             logic [31:0] proc_gap, logic [31:0] fwd_gap);
        write_reg(shs_pkg::CFG_HB_PERIOD, ping);
        write_reg(shs_pkg::CFG_PONG_TIMEOUT, pong);
        write_reg(shs_pkg::CFG_CMD_IDLE_MAX, cmd);
        write_reg(shs_pkg::CFG_MIN_PROCESS_GAP, proc_gap);
        write_reg(shs_pkg::CFG_SEND_GAP, fwd_gap);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        while (rsp_due_q.size() != 0)
            @(posedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rsp_quiet ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_due_q.size() == 0)
            begin
                $error("result item with no expectation: %h", rsp_item);
                n_fail++;
            end
            else
            begin
                rsp_due = rsp_due_q.pop_front();
                if (rsp_item !== rsp_due)
                    n_fail++;
                if (rsp_item.session_state !== rsp_due.session_state)
                    $error("session_state expected %0d got %0d",
                           rsp_due.session_state, rsp_item.session_state);
                if (rsp_item.send_ping !== rsp_due.send_ping)
                    $error("send_ping expected %0d got %0d",
                           rsp_due.send_ping, rsp_item.send_ping);
                if (rsp_item.send_pong !== rsp_due.send_pong)
                    $error("send_pong expected %0d got %0d",
                           rsp_due.send_pong, rsp_item.send_pong);
                if (rsp_item.send_greeting !== rsp_due.send_greeting)
                    $error("send_greeting expected %0d got %0d",
                           rsp_due.send_greeting, rsp_item.send_greeting);
                if (rsp_item.drop_client !== rsp_due.drop_client)
                    $error("drop_client expected %0d got %0d",
                           rsp_due.drop_client, rsp_item.drop_client);
                if (rsp_item.send_stop !== rsp_due.send_stop)
                    $error("send_stop expected %0d got %0d",
                           rsp_due.send_stop, rsp_item.send_stop);
                if (rsp_item.forward_cmd !== rsp_due.forward_cmd)
                    $error("forward_cmd expected %0d got %0d",
                           rsp_due.forward_cmd, rsp_item.forward_cmd);
                if (rsp_item.led_event !== rsp_due.led_event)
                    $error("led_event expected %0d got %0d",
                           rsp_due.led_event, rsp_item.led_event);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        shs_pkg::shs_req_t r;
        logic [31:0]       t_now;
        logic [31:0]       step_max;
        logic [31:0]       seq_next;
        int                pick;
        int                n_done;
        bit                ignored;

        regs.hb_period       = shs_pkg::HB_PERIOD_RST;
        regs.pong_timeout    = shs_pkg::PONG_TIMEOUT_RST;
        regs.cmd_idle_max    = shs_pkg::CMD_IDLE_MAX_RST;
        regs.min_process_gap = shs_pkg::MIN_PROCESS_GAP_RST;
        regs.send_gap        = shs_pkg::SEND_GAP_RST;
        trk                  = '0;

        // directed events at reset settings
        add_row(ev(shs_pkg::REQ_TICK, 32'd0, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0, 1'b0), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_ERROR, '1, shs_pkg::MSG_COMMAND, 1'b1, '1, 1'b1), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_ERR));
        add_row(ev(REQ_RSVD_LO, 32'd10, shs_pkg::MSG_PING, 1'b0, 32'd0, 1'b0), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(REQ_RSVD_HI, '1, shs_pkg::MSG_COMMAND, 1'b1, '1, 1'b1), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_TEXT, 32'd50, shs_pkg::MSG_CORRUPT, 1'b1, 32'd1, 1'b1), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_BINARY, 32'd60, shs_pkg::MSG_COMMAND, 1'b1, 32'd2, 1'b1),
                1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_CONNECT, 32'd100, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0, 1'b0),
                1'b1,
                res(shs_pkg::SES_STALE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_CONN));
        add_row(ev(shs_pkg::REQ_TEXT, 32'd200, shs_pkg::MSG_PONG, 1'b0, 32'd0, 1'b0), 1'b1,
                res(shs_pkg::SES_STALE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_TEXT, 32'd300, shs_pkg::MSG_PING, 1'b0, 32'd0, 1'b0), 1'b1,
                res(shs_pkg::SES_STALE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_TEXT, 32'd500, shs_pkg::MSG_COMMAND, 1'b1, 32'd5, 1'b1),
                1'b1,
                res(shs_pkg::SES_VALID, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                    shs_pkg::LED_NONE));
        // repeated sequence, next sequence, process gap met but send gap not
        add_row(ev(shs_pkg::REQ_TEXT, 32'd600, shs_pkg::MSG_COMMAND, 1'b1, 32'd5, 1'b1),
                1'b0, '0);
        add_row(ev(shs_pkg::REQ_TEXT, 32'd610, shs_pkg::MSG_COMMAND, 1'b1, 32'd6, 1'b1),
                1'b0, '0);
        add_row(ev(shs_pkg::REQ_TEXT, 32'd660, shs_pkg::MSG_COMMAND, 1'b0, '1, 1'b1),
                1'b0, '0);
        // flood, then processed command without data
        add_row(ev(shs_pkg::REQ_TEXT, 32'd670, shs_pkg::MSG_COMMAND, 1'b0, 32'd0, 1'b1),
                1'b0, '0);
        add_row(ev(shs_pkg::REQ_TEXT, 32'd720, shs_pkg::MSG_COMMAND, 1'b0, 32'd0, 1'b0),
                1'b0, '0);
        // command timeout, ping due, pong timeout
        add_row(ev(shs_pkg::REQ_TICK, 32'd1661, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0, 1'b0),
                1'b0, '0);
        add_row(ev(shs_pkg::REQ_TICK, 32'd5101, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0, 1'b0),
                1'b0, '0);
        add_row(ev(shs_pkg::REQ_TICK, 32'd15721, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0, 1'b0),
                1'b0, '0);
        // command with the link down
        add_row(ev(shs_pkg::REQ_TEXT, 32'd15800, shs_pkg::MSG_COMMAND, 1'b0, 32'd0, 1'b1),
                1'b0, '0);
        add_row(ev(shs_pkg::REQ_DISCONNECT, 32'd15900, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0,
                   1'b0), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                    shs_pkg::LED_DISC));
        add_row(ev(shs_pkg::REQ_TICK, '1, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0, 1'b0), 1'b1,
                res(shs_pkg::SES_DISC, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        // time wraps past zero
        add_row(ev(shs_pkg::REQ_CONNECT, 32'hFFFF_FFF0, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0,
                   1'b0), 1'b1,
                res(shs_pkg::SES_STALE, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_CONN));
        add_row(ev(shs_pkg::REQ_TICK, 32'h0000_1379, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0,
                   1'b0), 1'b0, '0);
        add_row(ev(shs_pkg::REQ_TEXT, 32'h0000_1400, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0,
                   1'b0), 1'b1,
                res(shs_pkg::SES_STALE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));
        add_row(ev(shs_pkg::REQ_BINARY, 32'h0000_2000, shs_pkg::MSG_CORRUPT, 1'b0, 32'd0,
                   1'b0), 1'b1,
                res(shs_pkg::SES_STALE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                    shs_pkg::LED_NONE));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_event(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].rsp);
        req_valid <= 1'b0;
        drain();

        t_now    = 32'h0000_3000;
        seq_next = 32'd10;
        for (int p = 0; p < N_PHASES; p++)
        begin
            // register setting for this phase
            case (p)
                0: step_max = 32'd400;
                1:
                begin
                    load_regs(32'd10, 32'd40, 32'd12, 32'd3, 32'd5);
                    step_max = 32'd15;
                end
                2:
                begin
                    load_regs(32'd1, 32'd1, 32'd1, 32'd0, 32'd0);
                    step_max = 32'd3;
                end
                3:
                begin
                    load_regs('1, '1, '1, '1, '1);
                    step_max = '1;
                end
                default:
                begin
                    for (int i = shs_pkg::CFG_SEND_GAP + 1; i < (1 << CFG_IDX_BITS); i++)
                        write_reg(CFG_IDX_BITS'(i), $urandom);
                    load_regs($urandom_range(1, 200), $urandom_range(1, 600),
                              $urandom_range(1, 150), $urandom_range(0, 20),
                              $urandom_range(0, 40));
                    step_max = 32'd60;
                end
            endcase

            n_done = 0;
            while (n_done < ITEMS_PER_PHASE)
            begin
                if (n_done % QUIET_SPAN == 0)
                begin
                    req_quiet = ($urandom_range(0, 3) == 0);
                    rsp_quiet = ($urandom_range(0, 3) == 0);
                end

                // advancing clock with occasional jumps anywhere
                if ($urandom_range(0, 24) == 0)
                    t_now = $urandom;
                else
                    t_now = t_now + $urandom_range(0, step_max);

                r.now_ms   = t_now;
                r.msg_kind = 2'($urandom_range(0, 3));
                r.has_seq  = 1'($urandom_range(0, 1));
                r.seq_num  = $urandom;
                r.has_data = 1'($urandom_range(0, 1));
                pick       = $urandom_range(0, 99);
                if (pick < 8)
                    r.req_type = shs_pkg::REQ_CONNECT;
                else if (pick < 12)
                    r.req_type = shs_pkg::REQ_DISCONNECT;
                else if (pick < 40)
                    r.req_type = shs_pkg::REQ_TICK;
                else if (pick < 86)
                begin
                    r.req_type = shs_pkg::REQ_TEXT;
                    pick       = $urandom_range(0, 99);
                    if (pick < 6)
                        r.msg_kind = shs_pkg::MSG_CORRUPT;
                    else if (pick < 18)
                        r.msg_kind = shs_pkg::MSG_PONG;
                    else if (pick < 30)
                        r.msg_kind = shs_pkg::MSG_PING;
                    else
                    begin
                        // mostly rising sequence numbers, some stale ones
                        r.msg_kind = shs_pkg::MSG_COMMAND;
                        r.has_data = ($urandom_range(0, 99) < 85);
                        r.has_seq  = ($urandom_range(0, 99) < 70);
                        if (r.has_seq)
                        begin
                            if ($urandom_range(0, 4) == 0)
                                r.seq_num = seq_next - $urandom_range(1, 4);
                            else
                            begin
                                r.seq_num = seq_next;
                                seq_next  = seq_next + $urandom_range(1, 3);
                            end
                        end
                    end
                end
                else if (pick < 93)
                    r.req_type = shs_pkg::REQ_BINARY;
                else if (pick < 97)
                    r.req_type = shs_pkg::REQ_ERROR;
                else
                    r.req_type = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));

                ignored = (r.req_type == REQ_RSVD_LO) || (r.req_type == REQ_RSVD_HI) ||
                          (r.req_type == shs_pkg::REQ_TEXT &&
                           r.msg_kind == shs_pkg::MSG_CORRUPT);
                send_event(r, 1'b0, '0);
                if (!ignored)
                    n_done++;
            end

            // highest sequence number sticks, so it comes last
            if (p == N_PHASES - 1)
            begin
                t_now = t_now + step_max;
                send_event(ev(shs_pkg::REQ_TEXT, t_now, shs_pkg::MSG_COMMAND, 1'b1, '1, 1'b1),
                           1'b0, '0);
                t_now = t_now + step_max;
                send_event(ev(shs_pkg::REQ_TEXT, t_now, shs_pkg::MSG_COMMAND, 1'b1, '1, 1'b1),
                           1'b0, '0);
            end
            req_valid <= 1'b0;
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_fail == 0 && rsp_due_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
